[rtl/bba_pkg.sv]
// bba_pkg: shared constants, codes, table entry and control/status structs
// for the buddy block allocator. No dependencies.
`default_nettype none

package bba_pkg;

  localparam int MAX_ORDER  = 6;
  localparam int OWNER_BITS = 16;
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ORDER_W    = 3;
  localparam int REQ_W      = 7;
  localparam int STATUS_W   = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC = 2'd0,
    ST_FAIL  = 2'd1,
    ST_LIST  = 2'd2
  } status_t;

  typedef struct packed {
    logic [ORDER_W-1:0]    size_log;
    logic [OWNER_BITS-1:0] owner;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic move_init;
    logic move_step;
    logic fill_init;
    logic fill_step;
    logic load_res;
    logic load_list;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic scan_done;
    logic exact;
    logic bigger;
    logic move_done;
    logic at_found;
    logic out_free;
    logic list_last;
  } dp_sts_t;

  // smallest w with 2^w >= req
  function automatic logic [ORDER_W-1:0] ceil_log2(input logic [REQ_W-1:0] req);
    logic [ORDER_W-1:0] w;
    w = ORDER_W'(REQ_W);
    for (int i = REQ_W - 1; i >= 0; i--) begin
      if (((REQ_W+1)'(1) << i) >= {1'b0, req}) begin
        w = ORDER_W'(i);
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/bba_in_if.sv]
// bba_in_if: request channel of the buddy block allocator.
// Depends on bba_pkg for field widths.
`default_nettype none

interface bba_in_if import bba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [OWNER_BITS-1:0] owner_id;
  logic [REQ_W-1:0]      request_units;

  modport source (output valid, output cmd, output owner_id, output request_units,
                  input ready);
  modport sink   (input valid, input cmd, input owner_id, input request_units,
                  output ready);
endinterface

`default_nettype wire

[rtl/bba_out_if.sv]
// bba_out_if: result channel of the buddy block allocator.
// Depends on bba_pkg for field widths.
`default_nettype none

interface bba_out_if import bba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [CNT_W-1:0]      block_count;
  logic [OWNER_BITS-1:0] block_owner;
  logic                  last;

  modport source (output valid, output status, output block_count, output block_owner,
                  output last, input ready);
  modport sink   (input valid, input status, input block_count, input block_owner,
                  input last, output ready);
endinterface

`default_nettype wire

[rtl/bba_cfg_if.sv]
// bba_cfg_if: pool order write channel of the buddy block allocator.
// Depends on bba_pkg for field widths.
`default_nettype none

interface bba_cfg_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ORDER_W-1:0] pool_order;

  modport source (output valid, output pool_order, input ready);
  modport sink   (input valid, input pool_order, output ready);
endinterface

`default_nettype wire

[rtl/bba_ctrl.sv]
// bba_ctrl: sequencing state machine of the buddy block allocator.
// Depends on bba_pkg; drives bba_dp through dp_cmd_t, reads dp_sts_t.
`default_nettype none

module bba_ctrl import bba_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_cmd,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_MOVE   = 7'b0000100,
    S_FILL   = 7'b0001000,
    S_RESULT = 7'b0010000,
    S_QRD    = 7'b0100000,
    S_QLD    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_cmd == CMD_QUERY) ? S_QRD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.bad) begin
          state_nxt = S_RESULT;
        end else if (sts.scan_done) begin
          if (sts.exact) begin
            cmd.fill_init = 1'b1;
            state_nxt     = S_FILL;
          end else if (sts.bigger) begin
            cmd.move_init = 1'b1;
            state_nxt     = S_MOVE;
          end else begin
            state_nxt = S_RESULT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MOVE: begin
        if (sts.move_done) begin
          cmd.fill_init = 1'b1;
          state_nxt     = S_FILL;
        end else begin
          cmd.move_step = 1'b1;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.at_found) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_res = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_QRD: begin
        state_nxt = S_QLD;
      end
      S_QLD: begin
        if (sts.out_free) begin
          cmd.load_list = 1'b1;
          state_nxt     = sts.list_last ? S_IDLE : S_QRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/bba_dp.sv]
// bba_dp: block table memory, scan/shift/fill pointers and result register.
// Depends on bba_pkg; commanded by bba_ctrl.
`default_nettype none

module bba_dp import bba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  in_cmd,
  input  logic [OWNER_BITS-1:0] in_owner_id,
  input  logic [REQ_W-1:0]      in_request_units,
  input  logic                  cfg_valid,
  input  logic [ORDER_W-1:0]    cfg_pool_order,
  output logic                  cfg_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [CNT_W-1:0]      out_block_count,
  output logic [OWNER_BITS-1:0] out_block_owner,
  output logic                  out_last
);

  entry_t mem [MAX_BLOCKS];

  logic [ORDER_W-1:0]    pool_order_r;
  logic [CNT_W-1:0]      count_r;
  logic                  e0_valid_r;
  logic [CNT_W-1:0]      idx_r;
  logic                  pend_r;
  logic [IDX_W-1:0]      pend_idx_r;
  logic                  exact_r, large_r, res_ok_r;
  logic [IDX_W-1:0]      exact_idx_r, large_idx_r;
  logic [ORDER_W-1:0]    large_size_r, want_r, sz_r;
  logic [OWNER_BITS-1:0] owner_r;
  logic                  bad_r;
  entry_t                rd_q_r;
  logic                  rd_fresh_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [CNT_W-1:0]      out_count_r;
  logic [OWNER_BITS-1:0] out_owner_r;
  logic                  out_last_r;

  logic [IDX_W-1:0]      rd_addr, wr_addr, f_idx;
  logic [ORDER_W-1:0]    f_size, k;
  entry_t                rd_entry, wr_data;
  logic                  wr_en, out_free, scan_issue, move_issue, at_found;
  logic [ORDER_W-1:0]    want_in;

  assign cfg_ready = 1'b1;
  assign want_in   = ceil_log2(in_request_units);

  // entry 0 reads as one free full-pool block until first written
  assign rd_entry = rd_fresh_r ? entry_t'{size_log: pool_order_r, owner: '0} : rd_q_r;

  assign f_idx  = exact_r ? exact_idx_r : large_idx_r;
  assign f_size = exact_r ? want_r : large_size_r;
  assign k      = exact_r ? '0 : (large_size_r - want_r);

  assign rd_addr    = idx_r[IDX_W-1:0];
  assign scan_issue = idx_r < count_r;
  assign move_issue = idx_r > {1'b0, f_idx};
  assign at_found   = idx_r == {1'b0, f_idx};
  assign out_free   = !out_valid_r || out_ready;

  assign wr_en   = (cmd.move_step && pend_r) || cmd.fill_step;
  assign wr_addr = cmd.fill_step ? idx_r[IDX_W-1:0] : (pend_idx_r + IDX_W'(k));
  always_comb begin
    if (!cmd.fill_step) begin
      wr_data = rd_entry;
    end else if (at_found) begin
      wr_data = '{size_log: want_r, owner: owner_r};
    end else begin
      wr_data = '{size_log: sz_r, owner: '0};
    end
  end

  always_comb begin
    sts           = '0;
    sts.bad       = bad_r;
    sts.scan_done = exact_r || (!pend_r && !scan_issue);
    sts.exact     = exact_r;
    sts.bigger    = large_r;
    sts.move_done = !pend_r && !move_issue;
    sts.at_found  = at_found;
    sts.out_free  = out_free;
    sts.list_last = idx_r == (count_r - CNT_W'(1));
  end

  // block table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r     <= mem[rd_addr];
    rd_fresh_r <= (rd_addr == '0) && !e0_valid_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_order_r <= ORDER_W'(MAX_ORDER);
      count_r      <= CNT_W'(1);
      e0_valid_r   <= 1'b0;
      pend_r       <= 1'b0;
      exact_r      <= 1'b0;
      large_r      <= 1'b0;
      res_ok_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pool_order_r <= (cfg_pool_order > ORDER_W'(MAX_ORDER)) ?
                        ORDER_W'(MAX_ORDER) : cfg_pool_order;
        count_r      <= CNT_W'(1);
        e0_valid_r   <= 1'b0;
      end else if (wr_en && wr_addr == '0) begin
        e0_valid_r <= 1'b1;
      end
      if (cmd.load) begin
        pend_r   <= 1'b0;
        exact_r  <= 1'b0;
        large_r  <= 1'b0;
        res_ok_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        pend_r <= scan_issue;
        if (pend_r && rd_entry.owner == '0 && !exact_r) begin
          if (rd_entry.size_log == want_r) begin
            exact_r <= 1'b1;
          end else if (rd_entry.size_log > want_r && !large_r) begin
            large_r <= 1'b1;
          end
        end
      end
      if (cmd.move_init) begin
        pend_r <= 1'b0;
      end
      if (cmd.move_step) begin
        pend_r <= move_issue;
      end
      if (cmd.fill_step && at_found) begin
        res_ok_r <= 1'b1;
        count_r  <= count_r + CNT_W'(k);
      end
      if (cmd.load_res || cmd.load_list) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pointers and payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r   <= '0;
      owner_r <= in_owner_id;
      want_r  <= want_in;
      bad_r   <= (in_cmd == CMD_ALLOC) &&
                 (in_request_units == '0 || in_owner_id == '0 || want_in > pool_order_r);
    end
    if (cmd.scan_step) begin
      if (scan_issue) begin
        idx_r      <= idx_r + CNT_W'(1);
        pend_idx_r <= idx_r[IDX_W-1:0];
      end
      if (pend_r && rd_entry.owner == '0 && !exact_r) begin
        if (rd_entry.size_log == want_r) begin
          exact_idx_r <= pend_idx_r;
        end else if (rd_entry.size_log > want_r && !large_r) begin
          large_idx_r  <= pend_idx_r;
          large_size_r <= rd_entry.size_log;
        end
      end
    end
    if (cmd.move_init) begin
      idx_r <= count_r - CNT_W'(1);
    end
    // shift entries above the split block up by k, highest first
    if (cmd.move_step && move_issue) begin
      idx_r      <= idx_r - CNT_W'(1);
      pend_idx_r <= idx_r[IDX_W-1:0];
    end
    // new free halves written top down, then the assigned block itself
    if (cmd.fill_init) begin
      idx_r <= {1'b0, f_idx} + CNT_W'(k);
      sz_r  <= f_size - ORDER_W'(1);
    end
    if (cmd.fill_step) begin
      idx_r <= idx_r - CNT_W'(1);
      sz_r  <= sz_r - ORDER_W'(1);
    end
    if (cmd.load_list) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.load_res) begin
      out_status_r <= res_ok_r ? ST_ALLOC : ST_FAIL;
      out_count_r  <= count_r;
      out_owner_r  <= res_ok_r ? owner_r : '0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_list) begin
      out_status_r <= ST_LIST;
      out_count_r  <= count_r;
      out_owner_r  <= rd_entry.owner;
      out_last_r   <= sts.list_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_count = out_count_r;
  assign out_block_owner = out_owner_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

[rtl/buddy_block_allocator.sv]
// Allocate-only buddy allocator over a pool of up to 64 units, one block table
// in address order. An allocate walks the block table, which takes one read and
// one write per cycle, with the scan, the shift of the entries above a split
// block and the write of the new halves; a query reads one entry per listed
// block, holding while the result side does not take it. One item is worked at
// a time; a finished result sits in an output register while the next item is
// taken. A pool order write is taken at any time, applies at once and restores
// one free full block.
// Depends on bba_pkg, bba_in_if, bba_out_if, bba_cfg_if, bba_ctrl, bba_dp.
`default_nettype none

module buddy_block_allocator import bba_pkg::*; (
  input logic clk,
  input logic rst_n,
  bba_in_if.sink    in_ch,
  bba_out_if.source out_ch,
  bba_cfg_if.sink   cfg_ch
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  bba_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .sts              (dp_sts),
    .in_cmd           (in_ch.cmd),
    .in_owner_id      (in_ch.owner_id),
    .in_request_units (in_ch.request_units),
    .cfg_valid        (cfg_ch.valid),
    .cfg_pool_order   (cfg_ch.pool_order),
    .cfg_ready        (cfg_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_block_count  (out_ch.block_count),
    .out_block_owner  (out_ch.block_owner),
    .out_last         (out_ch.last)
  );

endmodule

`default_nettype wire
